// ----- rtl/core/nvas_pkg.sv -----
// shared constants for the negative value ascending sorter
`default_nettype none

package nvas_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

endpackage

`default_nettype wire

// ----- rtl/core/negative_values_ascending_sort.sv -----
// top level: insertion sorter for negative values over a single ram
//
// channel   direction  handshake                  payload
// request   in         start && !busy             value, last
// result    out        res_valid (one cycle)      value_res, last_res, empty_res, overflow
//
// a non-negative or dropped request is not stored; a stored negative walks down
// the store, each entry read and moved up one place while it is larger, and is
// written where it lands, by the read-compare-write loop on the ram
// after a last request the results follow one per cycle, one ram read each
// reset clears the count and overflow flag; the ram needs no clearing pass
// the receiver cannot stall: each result shows for exactly one cycle
`default_nettype none

module negative_values_ascending_sort
	import nvas_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [31:0] value,
	input  wire logic        last,
	output      logic        res_valid,
	output      logic [31:0] value_res,
	output      logic        last_res,
	output      logic        empty_res,
	output      logic        overflow
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_INS_RD  = 2'd1;
	localparam logic [1:0] ST_INS_CMP = 2'd2;
	localparam logic [1:0] ST_EMIT    = 2'd3;

	logic [1:0] state_q;
	cnt_t       cnt_q;
	logic       ovf_q;
	data_t      v_q;
	logic       last_q;
	addr_t      pos_q;
	addr_t      k_q;
	logic       res_valid_q;
	logic       res_last_q;
	logic       res_empty_q;
	logic       res_ovf_q;

	logic  we;
	addr_t waddr;
	data_t wdata;
	logic  re;
	addr_t raddr;
	data_t rdata;
	logic  gt;
	logic  full;
	logic  k_last;

	assign full   = (cnt_q == cnt_t'(MAX_ITEMS));
	assign gt     = ($signed(rdata) > $signed(v_q));
	assign k_last = ((cnt_t'(k_q) + cnt_t'(1)) == cnt_q);

	// ram access: insert reads one entry, moves it up if larger; emit reads in order
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = v_q;
		re    = 1'b0;
		raddr = pos_q - addr_t'(1);
		case (state_q)
			ST_INS_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					re = 1'b1;
				end
			end
			ST_INS_CMP: begin
				we = 1'b1;
				if (gt) begin
					wdata = rdata;
				end
			end
			ST_EMIT: begin
				raddr = k_q;
				re    = (cnt_q != '0);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
			res_empty_q <= 1'b0;
			res_ovf_q   <= 1'b0;
			v_q         <= '0;
			last_q      <= 1'b0;
			pos_q       <= '0;
			k_q         <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						v_q    <= value;
						last_q <= last;
						pos_q  <= addr_t'(cnt_q);
						k_q    <= '0;
						if (value[31] && full) begin
							ovf_q <= 1'b1;
						end
						if (value[31] && !full) begin
							state_q <= ST_INS_RD;
						end else if (last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_INS_RD: begin
					if (pos_q == '0) begin
						cnt_q   <= cnt_q + cnt_t'(1);
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (gt) begin
						pos_q   <= pos_q - addr_t'(1);
						state_q <= ST_INS_RD;
					end else begin
						cnt_q   <= cnt_q + cnt_t'(1);
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					res_valid_q <= 1'b1;
					res_ovf_q   <= ovf_q;
					if (cnt_q == '0) begin
						res_empty_q <= 1'b1;
						res_last_q  <= 1'b1;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						res_empty_q <= 1'b0;
						res_last_q  <= k_last;
						k_q         <= k_q + addr_t'(1);
						if (k_last) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	nvas_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign value_res = res_empty_q ? '0 : rdata;
	assign last_res  = res_last_q;
	assign empty_res = res_empty_q;
	assign overflow  = res_ovf_q;

	// an empty result is always the only one of its run
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_empty_q |-> res_last_q)
		else $error("empty result without last flag");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(MAX_ITEMS))
		else $error("stored count beyond capacity");

	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS_CMP |-> $past(state_q) == ST_INS_RD)
		else $error("compare without a preceding read");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_last_q |-> cnt_q == '0 && !ovf_q)
		else $error("store not cleared at end of run");

	a_no_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_last_q |=> !res_valid_q)
		else $error("result after the last one of a run");

endmodule

`default_nettype wire

// ----- rtl/core/nvas_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module nvas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
